// File: design/pmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmq_pkg
// Shared types and constants for the PIR motion qualifier.
// ----------------------------------------------------------------------------
package pmq_pkg;

    localparam int unsigned TimeWidth  = 32;
    localparam int unsigned CountWidth = 32;
    localparam int unsigned CfgIdxW    = 2;
    localparam int unsigned CfgDataW   = 16;

    localparam logic [TimeWidth-1:0] TRIGGER_WINDOW_MS = 32'd1000;
    localparam logic [TimeWidth-1:0] NO_MOTION_TIME    = 32'hFFFF_FFFF;
    localparam logic [7:0]           TRIGGER_RUN_MAX   = 8'd255;

    localparam logic        RST_ENABLE   = 1'b1;
    localparam logic [15:0] RST_DEBOUNCE = 16'd2000;
    localparam logic [7:0]  RST_TRIGGERS = 8'd1;

    typedef enum logic [2:0] {
        OP_EDGE    = 3'd0,
        OP_POLL    = 3'd1,
        OP_QUALIFY = 3'd2,
        OP_CLEAR   = 3'd3,
        OP_RSTAT   = 3'd4,
        OP_STATUS  = 3'd5
    } opcode_t;

    typedef enum logic [CfgIdxW-1:0] {
        REG_ENABLE   = 2'd0,
        REG_DEBOUNCE = 2'd1,
        REG_TRIGGERS = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic        enable;
        logic [15:0] debounce_ms;
        logic [7:0]  required_triggers;
    } cfg_t;

    typedef struct packed {
        logic [2:0]           opcode;
        logic [TimeWidth-1:0] now_ms;
        logic                 pin_level;
    } item_t;

    typedef struct packed {
        logic                  motion_reported;
        logic                  motion_present;
        logic [CountWidth-1:0] motion_total;
        logic [CountWidth-1:0] false_positive_total;
        logic [TimeWidth-1:0]  time_since_motion;
        logic                  currently_detecting;
    } result_t;

endpackage

// File: design/pir_motion_qualifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pir_motion_qualifier
// Qualifies PIR sensor edges, polls and multi-trigger detections.
// ----------------------------------------------------------------------------
// Usage:
// A request on the input channel (in_valid, in_stall) carries an opcode, a
// millisecond time stamp and the pin level. Every request produces exactly one
// result on the output channel (out_valid, out_stall) with the motion flags,
// both counters, the time since the last motion and the live detect status.
// A request is captured in an input register; when the output register can
// load, the state is updated and the result is captured in the output
// register. One request is taken per cycle as long as results are drained.
// When the receiver stalls, the result holds; the input register still takes
// one more request, then in_stall rises until the result is taken.
// Configuration writes (cfg_wr_en, cfg_index, cfg_wdata) take effect at the
// next edge; the user must make them only while the block is idle, as the
// block itself does not enforce this. Writing enable low also drops any
// pending edge and the motion flag. Reset empties both registers, clears all
// state and restores enable 1, debounce 2000 ms, one trigger.
// ----------------------------------------------------------------------------
module pir_motion_qualifier (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [pmq_pkg::CfgIdxW-1:0]          cfg_index,
    input  logic [pmq_pkg::CfgDataW-1:0]         cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [2:0]                           opcode,
    input  logic [pmq_pkg::TimeWidth-1:0]        now_ms,
    input  logic                                 pin_level,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 motion_reported,
    output logic                                 motion_present,
    output logic [pmq_pkg::CountWidth-1:0]       motion_total,
    output logic [pmq_pkg::CountWidth-1:0]       false_positive_total,
    output logic [pmq_pkg::TimeWidth-1:0]        time_since_motion,
    output logic                                 currently_detecting
);

    pmq_pkg::cfg_t    cfg;
    logic             disable_clear;
    pmq_pkg::item_t   item_reg;
    logic             item_valid_reg;
    pmq_pkg::result_t res_next;
    pmq_pkg::result_t res_reg;
    logic             res_valid_reg;
    logic             advance;
    logic             take_in;

    pmq_cfg_regs u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .cfg           (cfg),
        .disable_clear (disable_clear)
    );

    // The output register can load when it is empty or being drained.
    assign advance  = item_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall = item_valid_reg && !advance;
    assign take_in  = in_valid && !in_stall;

    pmq_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .disable_clear (disable_clear),
        .fire          (advance),
        .item          (item_reg),
        .result        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= take_in || (item_valid_reg && !advance);
            if (advance)
                res_valid_reg <= 1'b1;
            else if (!out_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            item_reg.opcode    <= opcode;
            item_reg.now_ms    <= now_ms;
            item_reg.pin_level <= pin_level;
        end
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid            = res_valid_reg;
    assign motion_reported      = res_reg.motion_reported;
    assign motion_present       = res_reg.motion_present;
    assign motion_total         = res_reg.motion_total;
    assign false_positive_total = res_reg.false_positive_total;
    assign time_since_motion    = res_reg.time_since_motion;
    assign currently_detecting  = res_reg.currently_detecting;

`ifndef SYNTHESIS
    // A reported motion always leaves the motion flag set.
    a_report_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && motion_reported) |-> motion_present)
        else $error("reported motion without motion flag");

    // A reported motion is stamped with the request time itself.
    a_report_time: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && motion_reported) |->
        (time_since_motion == '0 || time_since_motion == pmq_pkg::NO_MOTION_TIME))
        else $error("reported motion with nonzero elapsed time");

    // Back-pressure reaches the input only when a request is held inside.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (item_valid_reg && res_valid_reg && out_stall))
        else $error("input stalled with room in the pipeline");
`endif

endmodule

// File: design/pmq_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmq_cfg_regs
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module pmq_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [pmq_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [pmq_pkg::CfgDataW-1:0]  cfg_wdata,
    output pmq_pkg::cfg_t                 cfg,
    output logic                          disable_clear
);

    pmq_pkg::cfg_t cfg_reg;
    pmq_pkg::cfg_t cfg_next;
    logic          clear_next;

    always_comb
    begin
        cfg_next   = cfg_reg;
        clear_next = 1'b0;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                pmq_pkg::REG_ENABLE:
                begin
                    cfg_next.enable = cfg_wdata[0];
                    clear_next      = ~cfg_wdata[0];
                end
                pmq_pkg::REG_DEBOUNCE: cfg_next.debounce_ms = cfg_wdata;
                pmq_pkg::REG_TRIGGERS: cfg_next.required_triggers = cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable            <= pmq_pkg::RST_ENABLE;
            cfg_reg.debounce_ms       <= pmq_pkg::RST_DEBOUNCE;
            cfg_reg.required_triggers <= pmq_pkg::RST_TRIGGERS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg           = cfg_reg;
    // Disabling the block drops the pending edge and the motion flag at once.
    assign disable_clear = clear_next;

endmodule

// File: design/pmq_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmq_core
// Motion state and the single-pass update for one request.
// ----------------------------------------------------------------------------
module pmq_core (
    input  logic              clk,
    input  logic              rst_n,
    input  pmq_pkg::cfg_t     cfg,
    input  logic              disable_clear,
    input  logic              fire,
    input  pmq_pkg::item_t    item,
    output pmq_pkg::result_t  result
);

    logic                              pending_reg, pending_next;
    logic                              flag_reg, flag_next;
    logic [pmq_pkg::CountWidth-1:0]    motion_cnt_reg, motion_cnt_next;
    logic [pmq_pkg::CountWidth-1:0]    reject_cnt_reg, reject_cnt_next;
    logic [pmq_pkg::TimeWidth-1:0]     last_motion_reg, last_motion_next;
    logic [pmq_pkg::TimeWidth-1:0]     last_accept_reg, last_accept_next;
    logic [pmq_pkg::TimeWidth-1:0]     last_trig_reg, last_trig_next;
    logic [7:0]                        run_reg, run_next;

    logic [pmq_pkg::TimeWidth-1:0]     since_accept;
    logic [pmq_pkg::TimeWidth-1:0]     since_trig;
    logic [pmq_pkg::TimeWidth-1:0]     since_motion;
    logic [pmq_pkg::TimeWidth-1:0]     debounce_wide;
    logic [7:0]                        run_upd;
    logic                              poll_ok;
    logic                              filtering;
    logic                              reported;

    assign debounce_wide = {16'd0, cfg.debounce_ms};
    assign since_accept  = item.now_ms - last_accept_reg;
    assign since_trig    = item.now_ms - last_trig_reg;
    assign poll_ok       = cfg.enable && pending_reg && (since_accept >= debounce_wide);
    assign filtering     = cfg.required_triggers > 8'd1;

    always_comb
    begin
        if (since_trig < pmq_pkg::TRIGGER_WINDOW_MS)
            run_upd = (run_reg == pmq_pkg::TRIGGER_RUN_MAX) ? run_reg : run_reg + 8'd1;
        else
            run_upd = 8'd1;
    end

    always_comb
    begin
        pending_next     = pending_reg;
        flag_next        = flag_reg;
        motion_cnt_next  = motion_cnt_reg;
        reject_cnt_next  = reject_cnt_reg;
        last_motion_next = last_motion_reg;
        last_accept_next = last_accept_reg;
        last_trig_next   = last_trig_reg;
        run_next         = run_reg;
        reported         = 1'b0;

        case (item.opcode)
            pmq_pkg::OP_EDGE:
            begin
                if (cfg.enable)
                    pending_next = 1'b1;
            end
            pmq_pkg::OP_POLL:
            begin
                if (poll_ok)
                begin
                    reported         = 1'b1;
                    last_accept_next = item.now_ms;
                    pending_next     = 1'b0;
                    flag_next        = 1'b1;
                    motion_cnt_next  = motion_cnt_reg + 32'd1;
                    last_motion_next = item.now_ms;
                end
            end
            pmq_pkg::OP_QUALIFY:
            begin
                if (filtering)
                begin
                    run_next       = run_upd;
                    last_trig_next = item.now_ms;
                end
                if (filtering && (run_upd < cfg.required_triggers))
                begin
                    reject_cnt_next = reject_cnt_reg + 32'd1;
                end
                else
                begin
                    reported         = 1'b1;
                    flag_next        = 1'b1;
                    motion_cnt_next  = motion_cnt_reg + 32'd1;
                    last_motion_next = item.now_ms;
                end
            end
            pmq_pkg::OP_CLEAR:
            begin
                pending_next = 1'b0;
                flag_next    = 1'b0;
            end
            pmq_pkg::OP_RSTAT:
            begin
                motion_cnt_next  = '0;
                reject_cnt_next  = '0;
                last_motion_next = '0;
            end
            default: ;
        endcase
    end

    // The status fields look at the state as it stands after this request.
    assign since_motion = item.now_ms - last_motion_next;

    always_comb
    begin
        result.motion_reported      = reported;
        result.motion_present       = flag_next;
        result.motion_total         = motion_cnt_next;
        result.false_positive_total = reject_cnt_next;
        result.time_since_motion    = (last_motion_next == '0) ? pmq_pkg::NO_MOTION_TIME
                                                                : since_motion;
        result.currently_detecting  = cfg.enable && item.pin_level
                                      && (since_motion < debounce_wide);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg     <= 1'b0;
            flag_reg        <= 1'b0;
            motion_cnt_reg  <= '0;
            reject_cnt_reg  <= '0;
            last_motion_reg <= '0;
            last_accept_reg <= '0;
            last_trig_reg   <= '0;
            run_reg         <= '0;
        end
        else if (disable_clear)
        begin
            pending_reg <= 1'b0;
            flag_reg    <= 1'b0;
        end
        else if (fire)
        begin
            pending_reg     <= pending_next;
            flag_reg        <= flag_next;
            motion_cnt_reg  <= motion_cnt_next;
            reject_cnt_reg  <= reject_cnt_next;
            last_motion_reg <= last_motion_next;
            last_accept_reg <= last_accept_next;
            last_trig_reg   <= last_trig_next;
            run_reg         <= run_next;
        end
    end

endmodule
